/* sv/lgnc_pkg.sv */
// Shared types and constants for the life grid neighbor census unit.
// Holds the action codes and the configuration register indexes.
// No dependencies.
package lgnc_pkg;

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_SET_LIVE = 2'd0,
    ACT_SET_DEAD = 2'd1,
    ACT_READ     = 2'd2,
    ACT_CENSUS   = 2'd3
  } action_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_EDGES = 2'd2;

  // Reset values of the size registers.
  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RESET = 7'd64;
  localparam logic [CFG_DATA_W-1:0] COL_COUNT_RESET = 7'd64;

endpackage

/* sv/life_grid_neighbor_census_unit.sv */
// Top level of the life grid neighbor census unit: cell grid storage,
// two-stage request pipeline, census logic and configuration registers.
// Depends on lgnc_pkg.
//
// Usage:
// - Requests enter on in_valid/in_stall with action, row and col. A request
//   is taken at a rising edge with in_valid high and in_stall low.
// - Each request gives exactly one result on out_valid/out_stall with
//   cell_alive, neighbor_count and coord_valid, in request order.
// - A request goes to the read stage, its result to the result register.
//   Throughput is one request per cycle while the receiver does not stall;
//   each request makes a single registered read of the row memories.
// - The grid sits in three copies of a row memory (one row per word), so the
//   row above, the row itself and the row below are read together. The row
//   being written is forwarded to a request that read it at the same edge.
// - Reset clears all row-valid flags at once, so the whole grid reads dead
//   immediately; there is no clearing pass. Sizes reset to full, wrap off.
// - When the receiver stalls, the result register holds; one more request
//   can still be taken into the read stage, after which in_stall rises.
// - The user must write configuration (cfg_write, cfg_index, cfg_data) only
//   while the unit holds no request; the unit does not enforce this.
module life_grid_neighbor_census_unit
  import lgnc_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic [5:0]             row,
  input  logic [5:0]             col,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   cell_alive,
  output logic [3:0]             neighbor_count,
  output logic                   coord_valid,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;

  // Configuration registers.
  logic [6:0] row_count;
  logic [6:0] col_count;
  logic       wrap_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= ROW_COUNT_RESET;
      col_count  <= COL_COUNT_RESET;
      wrap_edges <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_COUNT:  row_count  <= cfg_data;
        CFG_COL_COUNT:  col_count  <= cfg_data;
        CFG_WRAP_EDGES: wrap_edges <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake control.
  logic s1_valid;
  logic s1_adv;
  logic in_accept;

  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Request decode: effective sizes, range check and neighbor addresses.
  logic [RCW-1:0] nr;
  logic [RCW-1:0] row_ext;
  logic [RCW-1:0] row_plus;
  logic [6:0]     nc;
  logic [6:0]     col_ext;
  logic [6:0]     col_plus;
  logic           in_coord_ok;
  logic [RW-1:0]  rd_addr [3];
  logic [CIW-1:0] in_c;
  logic [CIW-1:0] in_cp;
  logic [CIW-1:0] in_cn;
  logic           in_rp_ok;
  logic           in_rn_ok;
  logic           in_cp_ok;
  logic           in_cn_ok;

  always_comb begin
    nr = (RCW'(row_count) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_count);
    nc = (col_count > 7'(MAX_COLS)) ? 7'(MAX_COLS) : col_count;
    row_ext  = RCW'(row);
    row_plus = row_ext + RCW'(1);
    col_ext  = {1'b0, col};
    col_plus = col_ext + 7'd1;
    in_coord_ok = (row_ext < nr) && (col_ext < nc);

    // Out-of-range requests read row and column zero; their result is masked.
    rd_addr[0] = '0;
    rd_addr[1] = '0;
    rd_addr[2] = '0;
    in_c  = '0;
    in_cp = '0;
    in_cn = '0;
    if (in_coord_ok) begin
      rd_addr[1] = RW'(row);
      rd_addr[0] = (row == 6'd0) ? RW'(nr - RCW'(1)) : RW'(row_ext - RCW'(1));
      rd_addr[2] = (row_plus >= nr) ? '0 : RW'(row_plus);
      in_c  = CIW'(col);
      in_cp = (col == 6'd0) ? CIW'(nc - 7'd1) : CIW'(col_ext - 7'd1);
      in_cn = (col_plus >= nc) ? '0 : CIW'(col_plus);
    end

    // In bounded mode, a neighbor off the grid counts as dead.
    in_rp_ok = wrap_edges || (row != 6'd0);
    in_rn_ok = wrap_edges || (row_plus < nr);
    in_cp_ok = wrap_edges || (col != 6'd0);
    in_cn_ok = wrap_edges || (col_plus < nc);
  end

  // Read stage registers.
  action_t        s1_action;
  logic           s1_coord_ok;
  logic [RW-1:0]  s1_addr [3];
  logic [CIW-1:0] s1_c;
  logic [CIW-1:0] s1_cp;
  logic [CIW-1:0] s1_cn;
  logic           s1_rp_ok;
  logic           s1_rn_ok;
  logic           s1_cp_ok;
  logic           s1_cn_ok;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action   <= action_t'(action);
      s1_coord_ok <= in_coord_ok;
      s1_addr     <= rd_addr;
      s1_c        <= in_c;
      s1_cp       <= in_cp;
      s1_cn       <= in_cn;
      s1_rp_ok    <= in_rp_ok;
      s1_rn_ok    <= in_rn_ok;
      s1_cp_ok    <= in_cp_ok;
      s1_cn_ok    <= in_cn_ok;
    end
  end

  // Grid storage: three identical row memories, one per read address.
  logic [MAX_COLS-1:0] grid_mem [3][MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data  [3];
  logic                rd_vld   [3];
  logic [MAX_ROWS-1:0] row_written;
  logic                wr_en;
  logic [MAX_COLS-1:0] new_row;

  always_ff @(posedge clk) begin
    for (int b = 0; b < 3; b++) begin
      if (wr_en) begin
        grid_mem[b][s1_addr[1]] <= new_row;
      end
      if (in_accept) begin
        rd_data[b] <= grid_mem[b][rd_addr[b]];
        rd_vld[b]  <= row_written[rd_addr[b]];
      end
    end
  end

  // A row never written reads as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (wr_en) begin
      row_written[s1_addr[1]] <= 1'b1;
    end
  end

  // Forwarding of the row written at the edge where this request read.
  logic                byp_en;
  logic [RW-1:0]       byp_row;
  logic [MAX_COLS-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_en <= 1'b0;
    end else if (in_accept) begin
      byp_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byp_row  <= s1_addr[1];
      byp_data <= new_row;
    end
  end

  // Census and cell update.
  logic [MAX_COLS-1:0] eff_row [3];
  logic                is_write;
  logic                res_alive;
  logic [3:0]          res_count;
  logic [7:0]          nb;

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (byp_en && (byp_row == s1_addr[b])) begin
        eff_row[b] = byp_data;
      end else begin
        eff_row[b] = rd_vld[b] ? rd_data[b] : '0;
      end
    end

    is_write = s1_action inside {ACT_SET_LIVE, ACT_SET_DEAD};
    new_row = eff_row[1];
    if (is_write) begin
      new_row[s1_c] = (s1_action == ACT_SET_LIVE);
    end
    wr_en = s1_valid && s1_adv && s1_coord_ok && is_write;

    nb[0] = s1_rp_ok && s1_cp_ok && eff_row[0][s1_cp];
    nb[1] = s1_rp_ok && eff_row[0][s1_c];
    nb[2] = s1_rp_ok && s1_cn_ok && eff_row[0][s1_cn];
    nb[3] = s1_cp_ok && eff_row[1][s1_cp];
    nb[4] = s1_cn_ok && eff_row[1][s1_cn];
    nb[5] = s1_rn_ok && s1_cp_ok && eff_row[2][s1_cp];
    nb[6] = s1_rn_ok && eff_row[2][s1_c];
    nb[7] = s1_rn_ok && s1_cn_ok && eff_row[2][s1_cn];

    res_alive = s1_coord_ok && new_row[s1_c];
    res_count = '0;
    if (s1_coord_ok && (s1_action == ACT_CENSUS)) begin
      res_count = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
                + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      cell_alive     <= res_alive;
      neighbor_count <= res_count;
      coord_valid    <= s1_coord_ok;
    end
  end

  // An out-of-range request reports a dead cell and no neighbors.
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !coord_valid |-> !cell_alive && (neighbor_count == 4'd0))
    else $error("out-of-range request returned nonzero result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neighbor_count <= 4'd8))
    else $error("neighbor count above eight");

  // Requests are held off only when both stages are full and the result waits.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

/* verif/tb.sv */
// Self-checking testbench for life_grid_neighbor_census_unit: directed table, then random phases.
// A shadow cell grid predicts results where the table gives none, and results are compared field by field in order.
// Depends on lgnc_pkg and the RTL top level.
module tb;
  import lgnc_pkg::*;

  localparam int GRID_ROWS   = 64;
  localparam int GRID_COLS   = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 29;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 45;
  localparam int NUM_PHASES  = 10;
  localparam int SCRIPT_LEN  = 30;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       alive;
    logic [3:0] count;
    logic       valid;
  } census_result_t;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    action_t               act;
    logic [5:0]            r;
    logic [5:0]            c;
    bit                    typed;
    census_result_t        want;
  } script_row_t;

  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic       wrap;
  } grid_setting_t;

  // Request rows carry filler in the register columns; register rows carry filler after them.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_READ,     6'd0,  6'd0,  1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_READ,     6'd63, 6'd63, 1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd63, 6'd63, 1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd0,  6'd0,  1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd63, 6'd63, 1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd0,  6'd1,  1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd1,  6'd0,  1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd1,  6'd1,  1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd0,  1'b1, '{1'b1, 4'd3, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd1,  6'd1,  1'b1, '{1'b1, 4'd3, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_DEAD, 6'd1,  6'd1,  1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd0,  1'b1, '{1'b1, 4'd2, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd62, 6'd62, 1'b1, '{1'b0, 4'd1, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd21, 6'd42, 1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_READ,     6'd42, 6'd21, 1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_DEAD, 6'd0,  6'd0,  1'b1, '{1'b0, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd1,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b1, CFG_UNUSED,  7'd127, ACT_READ,     6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b1, CFG_WRAP_EDGES, 7'd1, ACT_READ,    6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd63, 6'd63, 1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd63, 1'b0, '{1'b0, 4'd0, 1'b0}},
    // With no rows in use every coordinate is out of range.
    '{1'b1, CFG_ROW_COUNT, 7'd0, ACT_READ,     6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd0,  6'd0,  1'b1, '{1'b0, 4'd0, 1'b0}},
    // A single wrapped cell is its own neighbor eight times over.
    '{1'b1, CFG_ROW_COUNT, 7'd1, ACT_READ,     6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b1, CFG_COL_COUNT, 7'd1, ACT_READ,     6'd0,  6'd0,  1'b0, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_SET_LIVE, 6'd0,  6'd0,  1'b1, '{1'b1, 4'd0, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd0,  1'b1, '{1'b1, 4'd8, 1'b1}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd5,  6'd0,  1'b1, '{1'b0, 4'd0, 1'b0}},
    '{1'b0, CFG_ROW_COUNT, 7'd0, ACT_CENSUS,   6'd0,  6'd63, 1'b1, '{1'b0, 4'd0, 1'b0}}
  };

  localparam grid_setting_t FIXED_SETTINGS [8] = '{
    '{7'd64,  7'd64,  1'b1},
    '{7'd1,   7'd1,   1'b0},
    '{7'd3,   7'd5,   1'b1},
    '{7'd8,   7'd8,   1'b0},
    '{7'd127, 7'd127, 1'b1},
    '{7'd0,   7'd7,   1'b1},
    '{7'd2,   7'd64,  1'b1},
    '{7'd64,  7'd1,   1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             action;
  logic [5:0]             row;
  logic [5:0]             col;
  logic                   out_valid;
  logic                   out_stall;
  logic                   cell_alive;
  logic [3:0]             neighbor_count;
  logic                   coord_valid;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow of the grid and of the configuration registers.
  logic [GRID_COLS-1:0] live_rows [GRID_ROWS];
  logic [6:0]           rows_in_use;
  logic [6:0]           cols_in_use;
  logic                 wrap_on;

  census_result_t pending_results [$];
  int             fail_count;
  logic           no_idle;
  int             hold_ticket;

  life_grid_neighbor_census_unit #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .row(row),
    .col(col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_alive(cell_alive),
    .neighbor_count(neighbor_count),
    .coord_valid(coord_valid),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_size(logic [6:0] v, int cap);
    return (v > cap) ? cap : int'(v);
  endfunction

  function automatic logic [3:0] count_live_neighbors(int nr, int nc, int r, int c);
    int rs [3];
    int cs [3];
    int rr;
    int cc;
    logic [3:0] n;
    n = 4'd0;
    if (wrap_on) begin
      rs[0] = (r == 0) ? nr - 1 : r - 1;
      rs[1] = r;
      rs[2] = (r + 1 >= nr) ? 0 : r + 1;
      cs[0] = (c == 0) ? nc - 1 : c - 1;
      cs[1] = c;
      cs[2] = (c + 1 >= nc) ? 0 : c + 1;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          if (!(a == 1 && b == 1)) n += live_rows[rs[a]][cs[b]];
    end else begin
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (!(dr == 0 && dc == 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
            n += live_rows[rr][cc];
        end
    end
    return n;
  endfunction

  // Applies one request to the shadow grid and returns the result it should give.
  function automatic census_result_t apply_request(action_t act, logic [5:0] r, logic [5:0] c);
    census_result_t res;
    int nr;
    int nc;
    nr = eff_size(rows_in_use, GRID_ROWS);
    nc = eff_size(cols_in_use, GRID_COLS);
    res = '0;
    res.valid = (r < nr) && (c < nc);
    if (res.valid) begin
      if (act == ACT_SET_LIVE) live_rows[r][c] = 1'b1;
      else if (act == ACT_SET_DEAD) live_rows[r][c] = 1'b0;
      res.alive = live_rows[r][c];
      if (act == ACT_CENSUS) res.count = count_live_neighbors(nr, nc, r, c);
    end
    return res;
  endfunction

  // Mostly near the edges of the grid in use, so neighbors are found; some anywhere.
  function automatic logic [5:0] pick_coord(int n);
    int roll;
    roll = $urandom_range(99);
    if (n == 0 || roll >= 85) return 6'($urandom_range(63));
    if (roll >= 60 || n <= 8) return 6'($urandom_range(n - 1));
    if (roll < 30) return 6'($urandom_range(3));
    return 6'(n - 1 - int'($urandom_range(3)));
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input action_t act, input logic [5:0] r, input logic [5:0] c,
                              input bit typed, input census_result_t want);
    census_result_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    row      <= r;
    col      <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(act, r, c);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stops sending and waits until the unit has returned every result and gone quiet.
  task automatic settle_unit();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    settle_unit();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ROW_COUNT:  rows_in_use = val;
      CFG_COL_COUNT:  cols_in_use = val;
      CFG_WRAP_EDGES: wrap_on = val[0];
      default: ;
    endcase
  endtask

  initial begin : result_sink
    int served;
    out_stall = 1'b0;
    served = 0;
    forever begin
      @(negedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        for (int held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    census_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: alive %0d count %0d valid %0d",
                 $time, cell_alive, neighbor_count, coord_valid);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (cell_alive !== want.alive) begin
          $display("%0t: cell_alive mismatch: expected %0d actual %0d",
                   $time, want.alive, cell_alive);
          fail_count++;
        end
        if (neighbor_count !== want.count) begin
          $display("%0t: neighbor_count mismatch: expected %0d actual %0d",
                   $time, want.count, neighbor_count);
          fail_count++;
        end
        if (coord_valid !== want.valid) begin
          $display("%0t: coord_valid mismatch: expected %0d actual %0d",
                   $time, want.valid, coord_valid);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    grid_setting_t setting;
    logic [5:0]    junk;
    action_t       act;
    int            roll;
    int            nr;
    int            nc;
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_SET_LIVE;
    row         = 6'd0;
    col         = 6'd0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_ROW_COUNT;
    cfg_data    = 7'd0;
    no_idle     = 1'b0;
    hold_ticket = 0;
    fail_count  = 0;
    rows_in_use = ROW_COUNT_RESET;
    cols_in_use = COL_COUNT_RESET;
    wrap_on     = 1'b0;
    for (int k = 0; k < GRID_ROWS; k++) live_rows[k] = '0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      if (SCRIPT[k].is_cfg) write_register(SCRIPT[k].reg_idx, SCRIPT[k].reg_val);
      else send_request(SCRIPT[k].act, SCRIPT[k].r, SCRIPT[k].c, SCRIPT[k].typed,
                        SCRIPT[k].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 8) begin
        setting = FIXED_SETTINGS[p];
      end else begin
        setting.rows = 7'($urandom_range(1, 12));
        setting.cols = 7'($urandom_range(1, 12));
        setting.wrap = 1'($urandom_range(1));
      end
      junk = 6'($urandom_range(63));
      write_register(CFG_ROW_COUNT, setting.rows);
      write_register(CFG_COL_COUNT, setting.cols);
      // Upper data bits are junk; only bit zero sets the wrap mode.
      write_register(CFG_WRAP_EDGES, {junk, setting.wrap});
      no_idle <= (p == 2);
      nr = eff_size(rows_in_use, GRID_ROWS);
      nc = eff_size(cols_in_use, GRID_COLS);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // The receiver holds off while requests keep coming, so the pipeline backs up.
        if (p == 3 && k == 5) hold_ticket <= hold_ticket + 1;
        roll = $urandom_range(99);
        if (roll < 35) act = ACT_SET_LIVE;
        else if (roll < 50) act = ACT_SET_DEAD;
        else if (roll < 65) act = ACT_READ;
        else act = ACT_CENSUS;
        send_request(act, pick_coord(nr), pick_coord(nc), 1'b0, '0);
      end
    end

    settle_unit();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
